// ===== design/assert_macros.svh =====
// Assertion macros for the checker file of this block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with reset disable and a fixed message.
`define RRHT_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rrht assertion failed");

// Clocked assertion with reset disable and a caller-supplied message.
`define RRHT_ASSERT_MSG(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

// ===== design/rrht_pkg.sv =====
// Package for the rounded rectangle hit test: codes, state type and the arc table.
// No dependencies; used by rounded_rect_hit_test_top by scoped names.
package rrht_pkg;

    localparam int TRIG_FRAC  = 14;
    localparam int ARC_STEPS  = 5;
    localparam int COS_W      = 15;
    localparam int RAD_W      = 12;
    localparam int SIZE_W     = 13;
    localparam int POS_W      = 16;
    localparam int POINT_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int ARC_PROD_W = RAD_W + COS_W;
    localparam int CENTER_W   = 18;
    localparam int CHUNK_W    = 8;
    localparam int STEP_W     = 3;
    localparam int EDGE_W     = 5;

    localparam logic [STEP_W-1:0] LAST_STEP = 3'd4;
    localparam logic [EDGE_W-1:0] LAST_EDGE = 5'd19;

    // Q1.14 cosine of 0, 22.5, 45, 67.5 and 90 degrees.
    localparam logic [COS_W-1:0] COS_Q14 [ARC_STEPS] =
        '{15'd16384, 15'd15137, 15'd11585, 15'd6270, 15'd0};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POS_X         = 3'd0,
        CFG_POS_Y         = 3'd1,
        CFG_RECT_WIDTH    = 3'd2,
        CFG_RECT_HEIGHT   = 3'd3,
        CFG_CORNER_RADIUS = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ARC_X,
        ST_ARC_Y,
        ST_VERT,
        ST_DIFF,
        ST_MUL,
        ST_TEST,
        ST_FINISH
    } state_t;

endpackage

// ===== design/rounded_rect_hit_test_top.sv =====
// Rounded rectangle hit test: tests a point against a 20-vertex outline edge by edge.
// Depends on rrht_pkg for codes, the state type and the cosine table.
//
// Channel   Signals                                  Direction
// point     point_valid point_ready point_x point_y  into block
// hit       hit_valid hit_ready inside_res           out of block
// cfg       cfg_valid cfg_ready cfg_index cfg_data   into block, always ready
//
// A result is loaded once every edge has been tested, or earlier when an edge rejects the point.
// The next item can be taken in the cycle after the result is loaded.
// Each edge product is built by the shared signed multiplier, one 8-bit slice per cycle, with
// NCH = ceil((COORD_BITS+FRAC_BITS+1)/8) slices in each second operand.
// While the output register is full and not read, the block waits in its last state.
// Reset clears the configuration registers, the sequencer and the output valid.
module rounded_rect_hit_test_top #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         point_valid,
    output logic                                         point_ready,
    input  logic signed [rrht_pkg::POINT_W-1:0]          point_x,
    input  logic signed [rrht_pkg::POINT_W-1:0]          point_y,
    output logic                                         hit_valid,
    input  logic                                         hit_ready,
    output logic                                         inside_res,
    input  logic                                         cfg_valid,
    output logic                                         cfg_ready,
    input  logic        [rrht_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic        [rrht_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int Q_W   = COORD_BITS + FRAC_BITS;
    localparam int D_W   = Q_W + 1;
    localparam int CH    = rrht_pkg::CHUNK_W;
    localparam int NCH   = (D_W + CH - 1) / CH;
    localparam int B_W   = NCH * CH;
    localparam int K_W   = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int ACC_W = 2 * D_W + 2;
    localparam int P_W   = D_W + CH + 1;
    localparam int E_W   = Q_W + 10;
    localparam int C_W   = rrht_pkg::CENTER_W;
    localparam int AT_W  = rrht_pkg::RAD_W + FRAC_BITS + 1;
    localparam int RSH   = rrht_pkg::TRIG_FRAC - FRAC_BITS;
    localparam int AP_W  = rrht_pkg::ARC_PROD_W;
    localparam logic [AP_W-1:0] ARC_HALF = (AP_W'(2) << RSH) >> 2;

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [E_W-1:0] v);
        logic ovf;
        ovf = !((&v[E_W-1:Q_W-1]) || !(|v[E_W-1:Q_W-1]));
        if (ovf)
        begin
            return v[E_W-1] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
        end
        return v[Q_W-1:0];
    endfunction

    rrht_pkg::state_t state_reg, state_next;

    logic signed [rrht_pkg::POS_W-1:0] pos_x_reg, pos_y_reg;
    logic [rrht_pkg::SIZE_W-1:0]       rect_width_reg, rect_height_reg;
    logic [rrht_pkg::RAD_W-1:0]        corner_radius_reg;

    logic signed [Q_W-1:0]   px_reg, py_reg, x0_reg, y0_reg, x1_reg, y1_reg;
    logic [1:0]              vc_reg;
    logic [rrht_pkg::STEP_W-1:0] vj_reg;
    logic                    first_reg;
    logic [AT_W-1:0]         ax_reg, ay_reg;
    logic signed [D_W-1:0]   dx_reg, dy_reg;
    logic signed [B_W-1:0]   ex_reg, ey_reg;
    logic [K_W-1:0]          k_reg;
    logic                    phase_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [rrht_pkg::EDGE_W-1:0] edge_reg;
    logic                    verdict_reg;
    logic                    hit_valid_reg;
    logic                    inside_res_reg;

    logic                    out_free;
    logic                    load_result;
    logic [rrht_pkg::STEP_W-1:0] ix, iy, arc_idx;
    logic [AP_W-1:0]         arc_prod, arc_round;
    logic [AT_W-1:0]         arc_val;
    logic signed [C_W-1:0]   cx_lo, cx_hi, cy_lo, cy_hi, cx, cy;
    logic                    negx, negy;
    logic signed [E_W-1:0]   ax_ext, ay_ext, vx_full, vy_full;
    logic signed [Q_W-1:0]   vx_sat, vy_sat;
    logic signed [B_W-1:0]   b_src;
    logic [CH-1:0]           chunk_bits;
    logic signed [CH:0]      mul_b;
    logic signed [D_W-1:0]   mul_a;
    logic signed [P_W-1:0]   mul_p;
    logic signed [ACC_W-1:0] acc_base, acc_add;
    logic                    mul_last;

    // Vertex geometry for the vertex at corner vc_reg, step vj_reg.
    always_comb
    begin
        ix      = vc_reg[0] ? (rrht_pkg::LAST_STEP - vj_reg) : vj_reg;
        iy      = rrht_pkg::LAST_STEP - ix;
        arc_idx = (state_reg == rrht_pkg::ST_ARC_X) ? ix : iy;
        arc_prod  = AP_W'(corner_radius_reg) * AP_W'(rrht_pkg::COS_Q14[arc_idx]);
        arc_round = arc_prod + ARC_HALF;
        arc_val   = AT_W'(arc_round >> RSH);

        cx_lo = C_W'(pos_x_reg) + $signed(C_W'(corner_radius_reg));
        cx_hi = C_W'(pos_x_reg) + $signed(C_W'(rect_width_reg))
              - $signed(C_W'(corner_radius_reg));
        cy_lo = C_W'(pos_y_reg) + $signed(C_W'(corner_radius_reg));
        cy_hi = C_W'(pos_y_reg) + $signed(C_W'(rect_height_reg))
              - $signed(C_W'(corner_radius_reg));
        cx    = (vc_reg[0] ^ vc_reg[1]) ? cx_hi : cx_lo;
        cy    = vc_reg[1] ? cy_hi : cy_lo;
        negx  = !(vc_reg[0] ^ vc_reg[1]);
        negy  = !vc_reg[1];

        ax_ext  = $signed(E_W'(ax_reg));
        ay_ext  = $signed(E_W'(ay_reg));
        vx_full = (E_W'(cx) <<< FRAC_BITS) + (negx ? -ax_ext : ax_ext);
        vy_full = (E_W'(cy) <<< FRAC_BITS) + (negy ? -ay_ext : ay_ext);
        vx_sat  = sat_q(vx_full);
        vy_sat  = sat_q(vy_full);
    end

    // Shared multiplier: one signed slice of the second operand per cycle.
    always_comb
    begin
        b_src      = phase_reg ? ex_reg : ey_reg;
        chunk_bits = '0;
        for (int i = 0; i < NCH; i++)
        begin
            if (k_reg == K_W'(i))
            begin
                chunk_bits = b_src[i*CH +: CH];
            end
        end
        mul_b    = {(k_reg == K_W'(NCH - 1)) & chunk_bits[CH-1], chunk_bits};
        mul_a    = phase_reg ? dy_reg : dx_reg;
        mul_p    = mul_a * mul_b;
        acc_base = phase_reg ? acc_reg : (acc_reg <<< CH);
        acc_add  = phase_reg ? -ACC_W'(mul_p) : ACC_W'(mul_p);
        mul_last = phase_reg && (k_reg == '0);
    end

    // Output and handshake controls.
    always_comb
    begin
        point_ready = (state_reg == rrht_pkg::ST_IDLE);
        out_free    = !hit_valid_reg || hit_ready;
        load_result = (state_reg == rrht_pkg::ST_FINISH) && out_free;
        cfg_ready   = 1'b1;
        hit_valid   = hit_valid_reg;
        inside_res  = inside_res_reg;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rrht_pkg::ST_IDLE:
            begin
                if (point_valid)
                begin
                    state_next = rrht_pkg::ST_ARC_X;
                end
            end
            rrht_pkg::ST_ARC_X:  state_next = rrht_pkg::ST_ARC_Y;
            rrht_pkg::ST_ARC_Y:  state_next = rrht_pkg::ST_VERT;
            rrht_pkg::ST_VERT:
            begin
                state_next = first_reg ? rrht_pkg::ST_ARC_X : rrht_pkg::ST_DIFF;
            end
            rrht_pkg::ST_DIFF:   state_next = rrht_pkg::ST_MUL;
            rrht_pkg::ST_MUL:
            begin
                if (mul_last)
                begin
                    state_next = rrht_pkg::ST_TEST;
                end
            end
            rrht_pkg::ST_TEST:
            begin
                if (acc_reg[ACC_W-1] || (edge_reg == rrht_pkg::LAST_EDGE))
                begin
                    state_next = rrht_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = rrht_pkg::ST_ARC_X;
                end
            end
            rrht_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = rrht_pkg::ST_IDLE;
                end
            end
            default:             state_next = rrht_pkg::ST_IDLE;
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= rrht_pkg::ST_IDLE;
            hit_valid_reg     <= 1'b0;
            pos_x_reg         <= '0;
            pos_y_reg         <= '0;
            rect_width_reg    <= '0;
            rect_height_reg   <= '0;
            corner_radius_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_result)
            begin
                hit_valid_reg <= 1'b1;
            end
            else if (hit_ready)
            begin
                hit_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                unique case (rrht_pkg::cfg_reg_t'(cfg_index))
                    rrht_pkg::CFG_POS_X:         pos_x_reg <= cfg_data;
                    rrht_pkg::CFG_POS_Y:         pos_y_reg <= cfg_data;
                    rrht_pkg::CFG_RECT_WIDTH:
                        rect_width_reg <= cfg_data[rrht_pkg::SIZE_W-1:0];
                    rrht_pkg::CFG_RECT_HEIGHT:
                        rect_height_reg <= cfg_data[rrht_pkg::SIZE_W-1:0];
                    rrht_pkg::CFG_CORNER_RADIUS:
                        corner_radius_reg <= cfg_data[rrht_pkg::RAD_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            rrht_pkg::ST_IDLE:
            begin
                px_reg    <= sat_q(E_W'(point_x) <<< FRAC_BITS);
                py_reg    <= sat_q(E_W'(point_y) <<< FRAC_BITS);
                vc_reg    <= '0;
                vj_reg    <= '0;
                first_reg <= 1'b1;
                edge_reg  <= '0;
            end
            rrht_pkg::ST_ARC_X:
            begin
                ax_reg <= arc_val;
            end
            rrht_pkg::ST_ARC_Y:
            begin
                ay_reg <= arc_val;
            end
            rrht_pkg::ST_VERT:
            begin
                if (first_reg)
                begin
                    x0_reg <= vx_sat;
                    y0_reg <= vy_sat;
                end
                else
                begin
                    x1_reg <= vx_sat;
                    y1_reg <= vy_sat;
                end
                first_reg <= 1'b0;
                if (vj_reg == rrht_pkg::LAST_STEP)
                begin
                    vj_reg <= '0;
                    vc_reg <= vc_reg + 2'd1;
                end
                else
                begin
                    vj_reg <= vj_reg + rrht_pkg::STEP_W'(1);
                end
            end
            rrht_pkg::ST_DIFF:
            begin
                dx_reg    <= D_W'(x1_reg) - D_W'(x0_reg);
                dy_reg    <= D_W'(y1_reg) - D_W'(y0_reg);
                ex_reg    <= B_W'(px_reg) - B_W'(x0_reg);
                ey_reg    <= B_W'(py_reg) - B_W'(y0_reg);
                x0_reg    <= x1_reg;
                y0_reg    <= y1_reg;
                acc_reg   <= '0;
                k_reg     <= K_W'(NCH - 1);
                phase_reg <= 1'b0;
            end
            rrht_pkg::ST_MUL:
            begin
                acc_reg   <= acc_base + acc_add;
                phase_reg <= !phase_reg;
                if (phase_reg)
                begin
                    k_reg <= k_reg - K_W'(1);
                end
            end
            rrht_pkg::ST_TEST:
            begin
                verdict_reg <= !acc_reg[ACC_W-1];
                edge_reg    <= edge_reg + rrht_pkg::EDGE_W'(1);
            end
            rrht_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    inside_res_reg <= verdict_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== design/rrht_checker.sv =====
// Port-level checker for rounded_rect_hit_test_top, bound to the top level below.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module rrht_checker (
    input logic clk,
    input logic rst_n,
    input logic point_valid,
    input logic point_ready,
    input logic hit_valid,
    input logic hit_ready,
    input logic inside_res
);

    logic in_take;
    logic out_stall;

    assign in_take   = point_valid && point_ready;
    assign out_stall = hit_valid && !hit_ready;

    // The block works on one item at a time.
    `RRHT_ASSERT(a_busy_after_accept, clk, rst_n, in_take |=> !point_ready)

    // A result never appears in the cycle right after an item is taken.
    `RRHT_ASSERT_MSG(a_no_early_hit, clk, rst_n, $rose(hit_valid) |-> !$past(in_take), "early")

    // A stalled result holds its valid and its value.
    `RRHT_ASSERT(a_result_holds, clk, rst_n, out_stall |=> hit_valid && $stable(inside_res))

endmodule

bind rounded_rect_hit_test_top rrht_checker u_rrht_checker (.*);

// ===== tb/sv/tb_rounded_rect_hit_test_top.sv =====
// Self-checking bench for rounded_rect_hit_test_top: a directed table, then random phases of
// configuration and point items, checked against fixed expectations or a cycle-free model of the outline test.
// Depends on rrht_pkg and on the rounded_rect_hit_test_top RTL only.
module tb_rounded_rect_hit_test_top;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int CORNERS    = 4;
    localparam int ARC_POINTS = 5;
    localparam int OUTLINE_N  = CORNERS * ARC_POINTS;
    localparam int ARC_SHIFT  = 14 - FRAC_BITS;
    localparam longint ARC_HALF = (longint'(1) << ARC_SHIFT) >> 1;
    localparam longint Q_ONE    = longint'(1) << FRAC_BITS;
    localparam longint Q_LIM    = longint'(1) << (COORD_BITS - 1 + FRAC_BITS);
    localparam int TAIL_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 1950;

    localparam logic [rrht_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [rrht_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum logic [1:0] {WANT_MODEL, WANT_OUT, WANT_IN} hit_want_t;
    typedef enum logic {ROW_CFG, ROW_POINT} row_kind_t;

    typedef struct packed {
        row_kind_t                            kind;
        logic [rrht_pkg::CFG_IDX_W-1:0]       index;
        logic [rrht_pkg::CFG_DATA_W-1:0]      data;
        logic signed [rrht_pkg::POINT_W-1:0]  x;
        logic signed [rrht_pkg::POINT_W-1:0]  y;
        hit_want_t                            want;
    } plan_row_t;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  point_valid;
    logic                                  point_ready;
    logic signed [rrht_pkg::POINT_W-1:0]   point_x;
    logic signed [rrht_pkg::POINT_W-1:0]   point_y;
    logic                                  hit_valid;
    logic                                  hit_ready;
    logic                                  inside_res;
    logic                                  cfg_valid;
    logic                                  cfg_ready;
    logic [rrht_pkg::CFG_IDX_W-1:0]        cfg_index;
    logic [rrht_pkg::CFG_DATA_W-1:0]       cfg_data;

    logic signed [rrht_pkg::POS_W-1:0]     cur_pos_x = '0;
    logic signed [rrht_pkg::POS_W-1:0]     cur_pos_y = '0;
    logic [rrht_pkg::SIZE_W-1:0]           cur_width = '0;
    logic [rrht_pkg::SIZE_W-1:0]           cur_height = '0;
    logic [rrht_pkg::RAD_W-1:0]            cur_radius = '0;

    logic                                  inside_q [$];
    hit_want_t                             point_want = WANT_MODEL;
    int                                    fail_count = 0;

    rounded_rect_hit_test_top #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .hit_valid   (hit_valid),
        .hit_ready   (hit_ready),
        .inside_res  (inside_res),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #12000000;
        $display("rounded_rect_hit_test_top: mismatch");
        $finish;
    end

    function automatic longint clamp_q(input longint v);
        if (v < -Q_LIM)
            return -Q_LIM;
        if (v > Q_LIM - 1)
            return Q_LIM - 1;
        return v;
    endfunction

    // Q1.14 cosine of m * 22.5 degrees; the sine is the same table read backward.
    function automatic longint cos_step(input int m);
        case (m)
            0: return 16384;
            1: return 15137;
            2: return 11585;
            3: return 6270;
            default: return 0;
        endcase
    endfunction

    function automatic longint arc_off(input longint r, input int m);
        return (r * cos_step(m) + ARC_HALF) >>> ARC_SHIFT;
    endfunction

    function automatic void outline_vertex(input int v, output longint vx, output longint vy);
        int     c;
        int     j;
        longint r;
        longint span_x;
        longint span_y;
        longint cx;
        longint cy;
        longint ox;
        longint oy;
        c = v / ARC_POINTS;
        j = v % ARC_POINTS;
        r = longint'(cur_radius);
        span_x = longint'(cur_width) - 2 * r;
        span_y = longint'(cur_height) - 2 * r;
        cx = longint'(cur_pos_x) + r + ((c == 1 || c == 2) ? span_x : 0);
        cy = longint'(cur_pos_y) + r + ((c >= 2) ? span_y : 0);
        ox = arc_off(r, (c % 2 == 0) ? j : ARC_POINTS - 1 - j);
        oy = arc_off(r, (c % 2 == 0) ? ARC_POINTS - 1 - j : j);
        if (c == 0 || c == 3)
            ox = -ox;
        if (c <= 1)
            oy = -oy;
        vx = clamp_q(cx * Q_ONE + ox);
        vy = clamp_q(cy * Q_ONE + oy);
    endfunction

    // The point is outside as soon as one edge has it strictly on its outer side.
    function automatic logic hit_inside(input logic signed [rrht_pkg::POINT_W-1:0] x,
                                        input logic signed [rrht_pkg::POINT_W-1:0] y);
        longint pxq;
        longint pyq;
        longint x0;
        longint y0;
        longint x1;
        longint y1;
        int     v;
        pxq = clamp_q(longint'(x) * Q_ONE);
        pyq = clamp_q(longint'(y) * Q_ONE);
        for (v = 0; v < OUTLINE_N; v++)
        begin
            outline_vertex(v, x0, y0);
            outline_vertex((v + 1) % OUTLINE_N, x1, y1);
            if ((x1 - x0) * (pyq - y0) < (y1 - y0) * (pxq - x0))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int idle_cycles();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return 0;
        if (pick < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rrht_pkg::CFG_POS_X:         cur_pos_x <= cfg_data;
                    rrht_pkg::CFG_POS_Y:         cur_pos_y <= cfg_data;
                    rrht_pkg::CFG_RECT_WIDTH:
                        cur_width <= cfg_data[rrht_pkg::SIZE_W-1:0];
                    rrht_pkg::CFG_RECT_HEIGHT:
                        cur_height <= cfg_data[rrht_pkg::SIZE_W-1:0];
                    rrht_pkg::CFG_CORNER_RADIUS:
                        cur_radius <= cfg_data[rrht_pkg::RAD_W-1:0];
                    default: ;
                endcase
            end
            if (hit_valid && hit_ready)
            begin
                if (inside_q.size() == 0)
                begin
                    $error("inside_res: result %0b with no expectation pending", inside_res);
                    fail_count++;
                end
                else
                begin
                    logic want;
                    want = inside_q.pop_front();
                    if (inside_res !== want)
                    begin
                        $error("inside_res: expected %0b, actual %0b", want, inside_res);
                        fail_count++;
                    end
                end
            end
            if (point_valid && point_ready)
            begin
                if (point_want == WANT_MODEL)
                    inside_q = {inside_q, hit_inside(point_x, point_y)};
                else
                    inside_q = {inside_q, logic'(point_want == WANT_IN)};
            end
        end
    end

    // Result side: random stalls, with occasional long stretches of steady readiness.
    initial
    begin
        int stall_left;
        int calm_left;
        stall_left = 0;
        calm_left = 0;
        hit_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 499) == 0)
                calm_left = $urandom_range(100, 400);
            if (stall_left > 0)
            begin
                hit_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                hit_ready <= 1'b1;
                if (calm_left == 0 && $urandom_range(0, 3) == 0)
                    stall_left = idle_cycles();
            end
        end
    end

    task automatic send_point(input logic signed [rrht_pkg::POINT_W-1:0] x,
                              input logic signed [rrht_pkg::POINT_W-1:0] y,
                              input hit_want_t want, input int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            point_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        point_x <= x;
        point_y <= y;
        point_want = want;
        point_valid <= 1'b1;
        do @(posedge clk); while (!point_ready);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        point_valid <= 1'b0;
        while (inside_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [rrht_pkg::CFG_IDX_W-1:0] index,
                             input logic [rrht_pkg::CFG_DATA_W-1:0] data);
        wait_drained();
        @(negedge clk);
        cfg_index <= index;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic int extreme_pos();
        int pick;
        pick = $urandom_range(0, 2);
        if (pick == 0)
            return -32768;
        if (pick == 1)
            return 32767;
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    task automatic configure_phase();
        int shape;
        int px;
        int py;
        int w;
        int h;
        int r;
        shape = $urandom_range(0, 9);
        if (shape < 6)
        begin
            px = int'($urandom_range(0, 4000)) - 2000;
            py = int'($urandom_range(0, 4000)) - 2000;
            w = $urandom_range(0, 800);
            h = $urandom_range(0, 800);
            r = $urandom_range(0, ((w < h) ? w : h) / 2);
        end
        else if (shape < 8)
        begin
            // Radius at least half the box: the outline may fold over itself.
            px = int'($urandom_range(0, 4000)) - 2000;
            py = int'($urandom_range(0, 4000)) - 2000;
            r = $urandom_range(0, 4095);
            w = $urandom_range(0, 2 * r);
            h = $urandom_range(0, 2 * r);
        end
        else if (shape == 8)
        begin
            px = extreme_pos();
            py = extreme_pos();
            w = ($urandom_range(0, 1) == 0) ? 8191 : $urandom_range(0, 8191);
            h = ($urandom_range(0, 1) == 0) ? 0 : 8191;
            r = ($urandom_range(0, 1) == 0) ? 4095 : 0;
        end
        else
        begin
            px = $urandom_range(0, 65535);
            py = $urandom_range(0, 65535);
            w = $urandom_range(0, 65535);
            h = $urandom_range(0, 65535);
            r = $urandom_range(0, 65535);
        end
        write_reg(rrht_pkg::CFG_POS_X, 16'(px));
        write_reg(rrht_pkg::CFG_POS_Y, 16'(py));
        write_reg(rrht_pkg::CFG_RECT_WIDTH, 16'(w));
        write_reg(rrht_pkg::CFG_RECT_HEIGHT, 16'(h));
        write_reg(rrht_pkg::CFG_CORNER_RADIUS, 16'(r));
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                      16'($urandom_range(0, 65535)));
    endtask

    // Most points fall around the box, some exactly on its straight sides.
    task automatic pick_point(output logic signed [rrht_pkg::POINT_W-1:0] x,
                              output logic signed [rrht_pkg::POINT_W-1:0] y);
        int pick;
        int m;
        int xi;
        int yi;
        pick = $urandom_range(0, 99);
        m = 4 + int'(cur_radius) / 2;
        xi = int'(cur_pos_x) - m + int'($urandom_range(0, int'(cur_width) + 2 * m));
        yi = int'(cur_pos_y) - m + int'($urandom_range(0, int'(cur_height) + 2 * m));
        if (pick < 10)
        begin
            xi = $urandom_range(0, 65535);
            yi = $urandom_range(0, 65535);
        end
        else if (pick < 18)
            xi = int'(cur_pos_x) + ($urandom_range(0, 1) ? int'(cur_width) : 0);
        else if (pick < 26)
            yi = int'(cur_pos_y) + ($urandom_range(0, 1) ? int'(cur_height) : 0);
        x = 16'(xi);
        y = 16'(yi);
    endtask

    initial
    begin
        plan_row_t                           plan [$];
        logic signed [rrht_pkg::POINT_W-1:0] x;
        logic signed [rrht_pkg::POINT_W-1:0] y;
        int                                  sent;
        int                                  phase_len;
        bit                                  calm;

        rst_n = 1'b0;
        point_valid = 1'b0;
        point_x = '0;
        point_y = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;

        plan = '{
            '{ROW_POINT, '0, '0, 16'sd0, 16'sd0, WANT_IN},
            '{ROW_POINT, '0, '0, 16'sh7fff, 16'sh8000, WANT_IN},
            '{ROW_CFG, rrht_pkg::CFG_POS_X, 16'd100, '0, '0, WANT_MODEL},
            '{ROW_CFG, rrht_pkg::CFG_POS_Y, 16'd100, '0, '0, WANT_MODEL},
            '{ROW_CFG, rrht_pkg::CFG_RECT_WIDTH, 16'd200, '0, '0, WANT_MODEL},
            '{ROW_CFG, rrht_pkg::CFG_RECT_HEIGHT, 16'd100, '0, '0, WANT_MODEL},
            '{ROW_CFG, rrht_pkg::CFG_CORNER_RADIUS, 16'd20, '0, '0, WANT_MODEL},
            '{ROW_POINT, '0, '0, 16'sd200, 16'sd150, WANT_IN},
            '{ROW_POINT, '0, '0, 16'sd200, 16'sd100, WANT_IN},
            '{ROW_POINT, '0, '0, 16'sd300, 16'sd150, WANT_IN},
            '{ROW_POINT, '0, '0, 16'sd100, 16'sd100, WANT_MODEL},
            '{ROW_POINT, '0, '0, 16'sd99, 16'sd150, WANT_OUT},
            '{ROW_POINT, '0, '0, 16'sd301, 16'sd150, WANT_OUT},
            '{ROW_POINT, '0, '0, 16'sd200, 16'sd99, WANT_OUT},
            '{ROW_POINT, '0, '0, 16'sh8000, 16'sh8000, WANT_OUT},
            '{ROW_POINT, '0, '0, 16'sh7fff, 16'sh7fff, WANT_OUT},
            '{ROW_CFG, CFG_SPARE_LO, 16'hffff, '0, '0, WANT_MODEL},
            '{ROW_CFG, CFG_SPARE_HI, 16'hffff, '0, '0, WANT_MODEL},
            '{ROW_POINT, '0, '0, 16'sd200, 16'sd150, WANT_IN},
            '{ROW_CFG, rrht_pkg::CFG_CORNER_RADIUS, 16'hffff, '0, '0, WANT_MODEL},
            '{ROW_POINT, '0, '0, 16'sd200, 16'sd150, WANT_MODEL},
            '{ROW_POINT, '0, '0, 16'sd0, 16'sd0, WANT_MODEL},
            '{ROW_POINT, '0, '0, 16'sd4000, 16'sd4000, WANT_MODEL},
            '{ROW_CFG, rrht_pkg::CFG_POS_X, 16'h7fff, '0, '0, WANT_MODEL},
            '{ROW_CFG, rrht_pkg::CFG_POS_Y, 16'h8000, '0, '0, WANT_MODEL},
            '{ROW_CFG, rrht_pkg::CFG_RECT_WIDTH, 16'hffff, '0, '0, WANT_MODEL},
            '{ROW_CFG, rrht_pkg::CFG_RECT_HEIGHT, 16'h1fff, '0, '0, WANT_MODEL},
            '{ROW_CFG, rrht_pkg::CFG_CORNER_RADIUS, 16'h0000, '0, '0, WANT_MODEL},
            '{ROW_POINT, '0, '0, 16'sh7fff, 16'sh8000, WANT_MODEL},
            '{ROW_POINT, '0, '0, 16'sh7fff, -16'sd100, WANT_MODEL},
            '{ROW_POINT, '0, '0, 16'sh8000, 16'sd0, WANT_MODEL},
            '{ROW_CFG, rrht_pkg::CFG_POS_X, 16'h8000, '0, '0, WANT_MODEL},
            '{ROW_CFG, rrht_pkg::CFG_POS_Y, 16'h7fff, '0, '0, WANT_MODEL},
            '{ROW_CFG, rrht_pkg::CFG_CORNER_RADIUS, 16'h0fff, '0, '0, WANT_MODEL},
            '{ROW_POINT, '0, '0, 16'sh8000, 16'sh7fff, WANT_MODEL},
            '{ROW_POINT, '0, '0, 16'sd0, 16'sd0, WANT_MODEL},
            '{ROW_POINT, '0, '0, 16'sh8000, 16'sh8000, WANT_MODEL}
        };

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
                write_reg(plan[i].index, plan[i].data);
            else
                send_point(plan[i].x, plan[i].y, plan[i].want, idle_cycles());
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            configure_phase();
            phase_len = $urandom_range(60, 180);
            if (phase_len > RANDOM_ITEMS - sent)
                phase_len = RANDOM_ITEMS - sent;
            calm = ($urandom_range(0, 3) == 0);
            repeat (phase_len)
            begin
                if ($urandom_range(0, 79) == 0)
                    wait_drained();
                pick_point(x, y);
                send_point(x, y, WANT_MODEL, calm ? 0 : idle_cycles());
                sent++;
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("rounded_rect_hit_test_top: match");
        else
            $display("rounded_rect_hit_test_top: mismatch");
        $finish;
    end

endmodule
